/* rtl/f2fx_pkg.sv */
// Shared types and constants for the float to fixed converter.
`default_nettype none
package f2fx_pkg;
  localparam int unsigned OpW = 64;
  localparam int unsigned InW = 84;
  localparam int unsigned OutW = 64;
  localparam int unsigned UserW = 3;

  localparam logic [1:0] PREC_HALF = 2'd0;
  localparam logic [1:0] PREC_SINGLE = 2'd1;
  localparam logic [1:0] PREC_DOUBLE = 2'd2;

  localparam logic [2:0] RM_NEAREST_EVEN = 3'd0;
  localparam logic [2:0] RM_PLUS_INF = 3'd1;
  localparam logic [2:0] RM_MINUS_INF = 3'd2;
  localparam logic [2:0] RM_ZERO = 3'd3;
  localparam logic [2:0] RM_NEAREST_AWAY = 3'd4;

  localparam logic [1:0] FR_ZERO = 2'd0;
  localparam logic [1:0] FR_BELOW = 2'd1;
  localparam logic [1:0] FR_HALF = 2'd2;
  localparam logic [1:0] FR_ABOVE = 2'd3;

  localparam logic [0:0] REG_FTZ = 1'b0;
  localparam logic [0:0] REG_FTZ_HALF = 1'b1;

  typedef struct packed {
    logic [63:0] operand_bits;
    logic [1:0] precision;
    logic [6:0] integer_width;
    logic [6:0] fraction_bits;
    logic unsigned_result;
    logic [2:0] round_mode;
  } f2fx_req_t;

  typedef struct packed {
    logic [63:0] fixed_value;
    logic invalid_flag;
    logic inexact_flag;
    logic denormal_flag;
  } f2fx_res_t;
endpackage
`default_nettype wire

/* rtl/f2fx_core.sv */
// Combinational conversion of one registered request into one result.
`default_nettype none
module f2fx_core (
  input  f2fx_pkg::f2fx_req_t req,
  input  logic                ftz,
  input  logic                ftz_half,
  output f2fx_pkg::f2fx_res_t res
);
  import f2fx_pkg::*;

  logic [6:0]  w;
  logic [6:0]  fb;
  logic [2:0]  rm;
  logic        neg;
  logic [10:0] exp_raw;
  logic        exp_max;
  logic [51:0] frac;
  logic [52:0] m;
  logic [63:0] mask;
  logic        is_half;
  logic signed [13:0] e;
  logic signed [13:0] k;
  logic [6:0]  s;
  logic [116:0] wide;
  logic [63:0] rem;
  logic [63:0] half_pt;
  logic [63:0] q;
  logic [63:0] r;
  logic [1:0]  fc;
  logic        big;
  logic        away;
  logic        special;
  logic [63:0] maxv;
  logic [63:0] lim;
  logic [63:0] val;
  logic        inv;
  logic        inx;
  logic        den;

  always_comb begin
    w = (req.integer_width == 7'd0) ? 7'd1 :
        (req.integer_width > 7'd64) ? 7'd64 : req.integer_width;
    fb = (req.fraction_bits > w) ? w : req.fraction_bits;
    rm = (req.round_mode > RM_NEAREST_AWAY) ? RM_ZERO : req.round_mode;
    is_half = (req.precision == PREC_HALF);
    mask = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
    if (is_half) begin
      neg = req.operand_bits[15];
      exp_raw = {6'd0, req.operand_bits[14:10]};
      exp_max = &req.operand_bits[14:10];
      frac = {42'd0, req.operand_bits[9:0]};
      m = {42'd0, exp_raw != 11'd0, req.operand_bits[9:0]};
      e = (exp_raw == 11'd0) ? -14'sd24 : $signed({3'd0, exp_raw}) - 14'sd25;
    end else if (req.precision == PREC_SINGLE) begin
      neg = req.operand_bits[31];
      exp_raw = {3'd0, req.operand_bits[30:23]};
      exp_max = &req.operand_bits[30:23];
      frac = {29'd0, req.operand_bits[22:0]};
      m = {29'd0, exp_raw != 11'd0, req.operand_bits[22:0]};
      e = (exp_raw == 11'd0) ? -14'sd149 : $signed({3'd0, exp_raw}) - 14'sd150;
    end else begin
      neg = req.operand_bits[63];
      exp_raw = req.operand_bits[62:52];
      exp_max = &req.operand_bits[62:52];
      frac = req.operand_bits[51:0];
      m = {exp_raw != 11'd0, req.operand_bits[51:0]};
      e = (exp_raw == 11'd0) ? -14'sd1074 : $signed({3'd0, exp_raw}) - 14'sd1075;
    end
    k = e + $signed({7'd0, fb});

    big = 1'b0;
    q = '0;
    fc = FR_ZERO;
    s = '0;
    wide = '0;
    rem = '0;
    half_pt = '0;
    if (exp_max) begin
      big = 1'b1;
    end else if (k >= 14'sd64) begin
      big = 1'b1;
    end else if (k >= 14'sd0) begin
      wide = {64'd0, m} << k[5:0];
      big = |wide[116:64];
      q = wide[63:0];
    end else if (k <= -14'sd64) begin
      fc = FR_BELOW;
    end else begin
      s = 7'(-k);
      q = {11'd0, m} >> s;
      rem = {11'd0, m} & ((64'd1 << s) - 64'd1);
      half_pt = 64'd1 << (s - 7'd1);
      if (rem == 64'd0) fc = FR_ZERO;
      else if (rem < half_pt) fc = FR_BELOW;
      else if (rem == half_pt) fc = FR_HALF;
      else fc = FR_ABOVE;
    end

    away = 1'b0;
    if (fc != FR_ZERO) begin
      case (rm)
        RM_NEAREST_EVEN: away = (fc == FR_ABOVE) || (fc == FR_HALF && q[0]);
        RM_PLUS_INF:     away = !neg;
        RM_MINUS_INF:    away = neg;
        RM_NEAREST_AWAY: away = (fc == FR_HALF) || (fc == FR_ABOVE);
        default:         away = 1'b0;
      endcase
    end
    r = q;
    if (away) begin
      if (&q) big = 1'b1;
      else r = q + 64'd1;
    end

    maxv = req.unsigned_result ? mask : (mask >> 1);
    lim = 64'd1 << (w - 7'd1);
    inv = 1'b0;
    inx = 1'b0;
    val = '0;
    if (!neg) begin
      if (big || r > maxv) begin
        inv = 1'b1;
        val = maxv;
      end else begin
        val = r;
        inx = fc != FR_ZERO;
      end
    end else if (req.unsigned_result) begin
      if (big || r != 64'd0) inv = 1'b1;
      else inx = fc != FR_ZERO;
    end else begin
      if (big || r > lim) begin
        inv = 1'b1;
        val = lim;
      end else begin
        val = 64'd0 - r;
        inx = fc != FR_ZERO;
      end
    end

    special = 1'b0;
    den = 1'b0;
    if (exp_max && frac != 52'd0) begin
      special = 1'b1;
      inv = 1'b1;
    end else if (exp_raw == 11'd0) begin
      if (frac == 52'd0) begin
        special = 1'b1;
      end else if (is_half ? ftz_half : ftz) begin
        special = 1'b1;
        den = !is_half;
      end
    end
    if (special) begin
      val = '0;
      inx = 1'b0;
      if (!(exp_max && frac != 52'd0)) inv = 1'b0;
    end

    res.fixed_value = val & mask;
    res.invalid_flag = inv;
    res.inexact_flag = inx;
    res.denormal_flag = den;
  end
endmodule
`default_nettype wire

/* rtl/float_to_fixed_converter.sv */
// Top level of the float to fixed converter: stream ports, registers, pipeline.
// One conversion per cycle: a request register feeds a
// single pass of conversion logic whose output lands in the result register.
// The request side stays ready whenever the result register is empty or being
// drained, so full throughput holds as long as the downstream side takes data.
`default_nettype none
module float_to_fixed_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operand_bits[63:0], precision[65:64], integer_width[72:66],
  // fraction_bits[79:73], unsigned_result[80], round_mode[83:81], zero fill
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // fixed_value[63:0]
  output logic [63:0] m_tdata,
  // invalid_flag[0], inexact_flag[1], denormal_flag[2]
  output logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import f2fx_pkg::*;

  logic       ftz;
  logic       ftz_half;
  f2fx_req_t  req;
  logic       req_valid;
  f2fx_res_t  res_comb;
  f2fx_res_t  res;
  logic       res_valid;
  logic       adv;

  assign pready = 1'b1;
  assign prdata = {31'd0, (paddr[2] == REG_FTZ_HALF) ? ftz_half : ftz};

  always_ff @(posedge clk) begin
    if (rst) begin
      ftz <= 1'b0;
      ftz_half <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'd0)) begin
      if (paddr[2] == REG_FTZ) ftz <= pwdata[0];
      else ftz_half <= pwdata[0];
    end
  end

  assign adv = !res_valid || m_tready;
  assign s_tready = adv || !req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv) res_valid <= req_valid;
      if (s_tready) req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) req <= f2fx_req_t'({s_tdata[63:0], s_tdata[65:64],
        s_tdata[72:66], s_tdata[79:73], s_tdata[80], s_tdata[83:81]});
    if (adv && req_valid) res <= res_comb;
  end

  f2fx_core u_core (
    .req      (req),
    .ftz      (ftz),
    .ftz_half (ftz_half),
    .res      (res_comb)
  );

  assign m_tvalid = res_valid;
  assign m_tdata = res.fixed_value;
  assign m_tuser = {res.denormal_flag, res.inexact_flag, res.invalid_flag};
endmodule
`default_nettype wire
